[sv/snapshot_ring_storage_allocator_assert.svh]
// Assertion macros shared by the snapshot ring storage allocator RTL.
`ifndef SNAPSHOT_RING_STORAGE_ALLOCATOR_ASSERT_SVH
`define SNAPSHOT_RING_STORAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SRSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/srsa_pkg.sv]
// Shared types and constants of the snapshot ring storage allocator.
`default_nettype none

package srsa_pkg;

    localparam int SRSA_FRAME_SLOTS = 32;
    localparam int SRSA_CNT_W       = 16;
    localparam int SRSA_FRAME_W     = 32;
    localparam int SRSA_IN_TDATA_W  = 48;
    localparam int SRSA_OUT_TDATA_W = 88;
    localparam int SRSA_DIV_STEPS   = 17;

    localparam logic [SRSA_CNT_W-1:0] SRSA_STORE_RESET = 16'd4096;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef struct packed {
        logic                  start;
        logic [SRSA_CNT_W:0]   dividend;
        logic [SRSA_CNT_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic                  done;
        logic [SRSA_CNT_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

[sv/srsa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module srsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/srsa_mod.sv]
// Bit-serial restoring remainder unit for the write position wrap.
`default_nettype none

module srsa_mod
    import srsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    localparam int STEP_W = $clog2(SRSA_DIV_STEPS);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [SRSA_CNT_W:0]   r_num;
    logic [SRSA_CNT_W-1:0] r_rem;
    logic [SRSA_CNT_W-1:0] r_div;
    logic [SRSA_CNT_W:0]   n_trial;
    logic                  n_fits;

    assign n_trial = {r_rem, r_num[SRSA_CNT_W]};
    assign n_fits  = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_num <= {r_num[SRSA_CNT_W-1:0], 1'b0};
                r_rem <= n_fits ? SRSA_CNT_W'(n_trial - {1'b0, r_div})
                                : n_trial[SRSA_CNT_W-1:0];
                if (r_step == STEP_W'(SRSA_DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[sv/snapshot_ring_storage_allocator.sv]
// Snapshot ring storage allocator: top level with request sequencer and slot count memory.
//
// Requests enter on the s_axis channel: tuser carries the request kind (allocate, query,
// init, no operation), tdata carries the entry count and the queried frame number.
// Every request gives exactly one result on the m_axis channel with the span start, the
// frame number, the oldest frame still held and the valid and no-space flags.
// The block works on one request at a time; s_axis_tready is high only while it waits.
// A query, init or no-operation request goes straight to the output step, which registers
// its result once the output register is free. An allocation retires the oldest frame first
// when the frame ring is full, then checks for space, releasing older frames from the slot
// memory one at a time until the entries fit or none is left; a failed check gives a
// no-space result. After a fit is written to the slot memory, the bit-serial remainder
// wraps the write position unless the store size is zero. The sequencer returns to idle as
// a result is stored. The storage size register is written through i_cfg_we and i_cfg_wdata.
// Reset restores a 4096-entry store and clears all pointers, frame numbers and valid bits.
// The slot counts are masked by per-slot valid bits, so no clearing pass is needed.
// A finished result waits in the output register while m_axis_tready is low; the
// sequencer holds its last step until the register is free.
`default_nettype none
`include "snapshot_ring_storage_allocator_assert.svh"

module snapshot_ring_storage_allocator
    import srsa_pkg::*;
#(
    parameter int FRAME_SLOTS = SRSA_FRAME_SLOTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [SRSA_CNT_W-1:0]       i_cfg_wdata,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_count [15:0], query_frame [47:16]
    input  wire logic [SRSA_IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // span_start [15:0], frame_id [47:16], oldest_valid [79:48], frame_valid [80],
    // no_space [81], zero [87:82]
    output logic [SRSA_OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int SLOT_W = $clog2(FRAME_SLOTS);
    localparam logic [63:0] WRAP_K64 = 64'h1_0000_0000 % 64'(FRAME_SLOTS);
    localparam logic [SLOT_W:0] WRAP_K = WRAP_K64[SLOT_W:0];
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(FRAME_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SRSA_FRAME_W-1:0] KEEP_DEPTH = SRSA_FRAME_W'(FRAME_SLOTS - 1);
    localparam logic [SRSA_FRAME_W-1:0] RING_DEPTH = SRSA_FRAME_W'(FRAME_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RET,
        S_CHECK,
        S_REL,
        S_DIV,
        S_PUSH
    } t_state;

    t_state                  r_state;
    logic [SRSA_CNT_W-1:0]   r_storage;
    logic [SRSA_CNT_W-1:0]   r_free;
    logic [SRSA_CNT_W-1:0]   r_wp;
    logic [SRSA_FRAME_W-1:0] r_next_frame;
    logic [SRSA_FRAME_W-1:0] r_oldest_frame;
    logic [SLOT_W-1:0]       r_next_slot;
    logic [SLOT_W-1:0]       r_oldest_slot;
    logic [FRAME_SLOTS-1:0]  r_vld;
    logic [SRSA_CNT_W-1:0]   r_count;
    logic [SRSA_CNT_W-1:0]   r_res_span;
    logic [SRSA_FRAME_W-1:0] r_res_fid;
    logic                    r_res_valid;
    logic                    r_res_nospace;
    logic                    r_out_vld;
    logic [SRSA_OUT_TDATA_W-1:0] r_out_data;

    t_req                    w_req;
    logic [SRSA_CNT_W-1:0]   w_in_count;
    logic [SRSA_FRAME_W-1:0] w_in_query;
    logic                    w_accept;
    logic                    w_ring_full;
    logic                    w_short;
    logic                    w_ram_we;
    logic [SLOT_W-1:0]       w_raddr;
    logic [SRSA_CNT_W-1:0]   w_ram_rdata;
    logic [SRSA_CNT_W-1:0]   w_rd_cnt;
    t_mod_req                w_mod_req;
    t_mod_rsp                w_mod_rsp;
    logic                    w_out_free;

    logic [SLOT_W:0]         n_ret_sum;
    logic [SLOT_W-1:0]       n_ret_slot;
    logic [SRSA_CNT_W:0]     n_add;
    logic [SRSA_CNT_W-1:0]   n_free_sat;
    logic [SLOT_W-1:0]       n_next_slot;
    logic [SLOT_W-1:0]       n_oldest_slot;

    assign w_req      = t_req'(s_axis_tuser);
    assign w_in_count = s_axis_tdata[SRSA_CNT_W-1:0];
    assign w_in_query = s_axis_tdata[SRSA_CNT_W +: SRSA_FRAME_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    assign w_ring_full = (r_next_frame - r_oldest_frame) > KEEP_DEPTH;
    assign w_short     = r_free < r_count;

    assign n_ret_sum  = ((r_next_frame >= KEEP_DEPTH) ? '0 : WRAP_K)
                      + {1'b0, r_next_slot} + (SLOT_W + 1)'(1);
    assign n_ret_slot = (n_ret_sum >= SLOTS_X) ? SLOT_W'(n_ret_sum - SLOTS_X)
                                               : n_ret_sum[SLOT_W-1:0];

    assign n_next_slot   = (r_next_frame == '1 || r_next_slot == LAST_SLOT)
                         ? '0 : r_next_slot + SLOT_W'(1);
    assign n_oldest_slot = (r_oldest_frame == '1 || r_oldest_slot == LAST_SLOT)
                         ? '0 : r_oldest_slot + SLOT_W'(1);

    assign w_raddr  = (r_state == S_IDLE) ? r_next_slot : r_oldest_slot;
    assign w_rd_cnt = ((r_state == S_RET) ? r_vld[r_next_slot] : r_vld[r_oldest_slot])
                    ? w_ram_rdata : '0;

    assign n_add      = {1'b0, r_free} + {1'b0, w_rd_cnt};
    assign n_free_sat = n_add[SRSA_CNT_W] ? '1 : n_add[SRSA_CNT_W-1:0];

    assign w_ram_we = (r_state == S_CHECK) && !w_short;

    assign w_mod_req.start    = w_ram_we && (r_storage != '0);
    assign w_mod_req.dividend = {1'b0, r_wp} + {1'b0, r_count};
    assign w_mod_req.divisor  = r_storage;

    srsa_ram #(
        .WIDTH (SRSA_CNT_W),
        .DEPTH (FRAME_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_next_slot),
        .i_wdata (r_count),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    srsa_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_storage      <= SRSA_STORE_RESET;
            r_free         <= SRSA_STORE_RESET;
            r_wp           <= '0;
            r_next_frame   <= '0;
            r_oldest_frame <= '0;
            r_next_slot    <= '0;
            r_oldest_slot  <= '0;
            r_vld          <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_storage <= i_cfg_wdata;
            end
            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count       <= w_in_count;
                        r_res_span    <= '0;
                        r_res_fid     <= '0;
                        r_res_valid   <= (w_req == REQ_QUERY) && (w_in_query >= r_oldest_frame);
                        r_res_nospace <= 1'b0;
                        case (w_req)
                            REQ_ALLOC: begin
                                if (w_ring_full) begin
                                    r_oldest_frame <= r_next_frame - KEEP_DEPTH;
                                    r_oldest_slot  <= n_ret_slot;
                                    r_state        <= S_RET;
                                end else begin
                                    r_state <= S_CHECK;
                                end
                            end
                            REQ_INIT: begin
                                r_free         <= r_storage;
                                r_wp           <= '0;
                                r_next_frame   <= '0;
                                r_oldest_frame <= '0;
                                r_next_slot    <= '0;
                                r_oldest_slot  <= '0;
                                r_vld          <= '0;
                                r_state        <= S_PUSH;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_RET: begin
                    r_free             <= n_free_sat;
                    r_vld[r_next_slot] <= 1'b0;
                    r_state            <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_short && (r_oldest_frame != r_next_frame)) begin
                        r_state <= S_REL;
                    end else if (w_short) begin
                        r_res_nospace <= 1'b1;
                        r_state       <= S_PUSH;
                    end else begin
                        r_vld[r_next_slot] <= 1'b1;
                        r_free             <= r_free - r_count;
                        r_res_span         <= r_wp;
                        r_res_fid          <= r_next_frame;
                        r_next_frame       <= r_next_frame + SRSA_FRAME_W'(1);
                        r_next_slot        <= n_next_slot;
                        if (r_storage == '0) begin
                            r_wp    <= '0;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_REL: begin
                    r_free               <= n_free_sat;
                    r_vld[r_oldest_slot] <= 1'b0;
                    r_oldest_frame       <= r_oldest_frame + SRSA_FRAME_W'(1);
                    r_oldest_slot        <= n_oldest_slot;
                    r_state              <= S_CHECK;
                end
                S_DIV: begin
                    if (w_mod_rsp.done) begin
                        r_wp    <= w_mod_rsp.rem;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out_data <= {6'b0, r_res_nospace, r_res_valid, r_oldest_frame,
                                       r_res_fid, r_res_span};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    `SRSA_ASSERT_NXT(a_accept_one_at_a_time, i_clk, i_rst_n, w_accept, !s_axis_tready, "request accepted while another is in work")
    `SRSA_ASSERT_IMP(a_ring_depth, i_clk, i_rst_n, r_state == S_IDLE, (r_next_frame - r_oldest_frame) <= RING_DEPTH, "frame ring holds more frames than slots")
    `SRSA_ASSERT_IMP(a_alloc_fits, i_clk, i_rst_n, w_ram_we, r_free >= r_count, "frame written without enough free entries")
    `SRSA_ASSERT_IMP(a_mod_done_in_div, i_clk, i_rst_n, w_mod_rsp.done, r_state == S_DIV, "remainder finished outside the wrap step")

endmodule

`default_nettype wire
